@@ src/crl_pkg.sv @@
package crl_pkg;

   // Coordinate and span widths
   localparam int COORD_W = 16;
   localparam int SPAN_W  = COORD_W + 1;

   // Frame geometry
   localparam int MAX_DIM   = 4096;
   localparam int DIM_W     = 13;
   localparam int IN_FRAME_W = $clog2(MAX_DIM);
   localparam int INDEX_W   = 24;
   localparam int COLOR_W   = 32;

   // Command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Register map
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_W'(1);
   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(320);
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(200);
   localparam logic [DIM_W-1:0] DIM_LIMIT          = DIM_W'(MAX_DIM);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified request
   typedef struct packed {
      logic                      command;
      logic [COLOR_W-1:0]        color;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [COORD_W-1:0]        long_len;
      logic [COORD_W-1:0]        short_len;
      logic                      long_neg;
      logic                      short_neg;
      logic                      row_major;
   } line_entry_type;

endpackage

@@ src/crl_front.sv @@
module crl_front (
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [crl_pkg::COLOR_W-1:0]        req_line_color,
   input  logic signed [crl_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [crl_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [crl_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [crl_pkg::COORD_W-1:0] req_end_y,
   input  logic                               queue_full,
   output logic                               push_valid,
   output crl_pkg::line_entry_type            push_entry
);
   import crl_pkg::*;

   logic signed [SPAN_W-1:0] dx;
   logic signed [SPAN_W-1:0] dy;
   logic [SPAN_W-1:0]        dx_abs;
   logic [SPAN_W-1:0]        dy_abs;
   logic [COORD_W-1:0]       mag_x;
   logic [COORD_W-1:0]       mag_y;
   logic                     row_major;

   // Signed spans; magnitudes fit in COORD_W bits
   assign dx = {req_end_x[COORD_W-1], req_end_x} - {req_start_x[COORD_W-1], req_start_x};
   assign dy = {req_end_y[COORD_W-1], req_end_y} - {req_start_y[COORD_W-1], req_start_y};
   assign dx_abs = dx[SPAN_W-1] ? -dx : dx;
   assign dy_abs = dy[SPAN_W-1] ? -dy : dy;
   assign mag_x = dx_abs[COORD_W-1:0];
   assign mag_y = dy_abs[COORD_W-1:0];

   // Long axis is x on a tie
   assign row_major = (mag_y > mag_x);

   // Classified entry
   always_comb begin
      push_entry.command  = req_command;
      push_entry.color    = req_line_color;
      push_entry.origin_x = req_start_x;
      push_entry.origin_y = req_start_y;
      push_entry.row_major = row_major;
      if (row_major) begin
         push_entry.long_len  = mag_y;
         push_entry.short_len = mag_x;
         push_entry.long_neg  = dy[SPAN_W-1];
         push_entry.short_neg = dx[SPAN_W-1];
      end else begin
         push_entry.long_len  = mag_x;
         push_entry.short_len = mag_y;
         push_entry.long_neg  = dx[SPAN_W-1];
         push_entry.short_neg = dy[SPAN_W-1];
      end
   end

   // Handshake into the queue
   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

endmodule

@@ src/crl_queue.sv @@
module crl_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  crl_pkg::line_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output crl_pkg::line_entry_type pop_entry
);
   import crl_pkg::*;

   line_entry_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ src/crl_back.sv @@
module crl_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [crl_pkg::DIM_W-1:0]     frame_width,
   input  logic [crl_pkg::DIM_W-1:0]     frame_height,
   input  logic                          entry_valid,
   input  crl_pkg::line_entry_type       entry,
   output logic                          entry_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_inside_res,
   output logic [crl_pkg::INDEX_W-1:0]   rsp_pixel_index,
   output logic [crl_pkg::COLOR_W-1:0]   rsp_pixel_color,
   output logic                          rsp_last
);
   import crl_pkg::*;

   // Line walker state
   logic                      active_ff;
   logic                      active_in;
   logic signed [COORD_W-1:0] cur_x_ff;
   logic signed [COORD_W-1:0] cur_x_in;
   logic signed [COORD_W-1:0] cur_y_ff;
   logic signed [COORD_W-1:0] cur_y_in;
   logic [COORD_W-1:0]        remain_ff;
   logic [COORD_W-1:0]        remain_in;
   logic [COORD_W-1:0]        frac_ff;
   logic [COORD_W-1:0]        frac_in;
   logic [COORD_W-1:0]        long_len_ff;
   logic [COORD_W-1:0]        short_len_ff;
   logic                      long_neg_ff;
   logic                      short_neg_ff;
   logic                      row_major_ff;
   logic [COLOR_W-1:0]        color_ff;
   logic                      load;

   // Output register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      rsp_inside_ff;
   logic [INDEX_W-1:0]        rsp_index_ff;
   logic [COLOR_W-1:0]        rsp_color_ff;
   logic                      rsp_last_ff;

   logic                      out_free;
   logic                      is_step;
   logic                      emit;
   logic                      last_pix;
   logic [COORD_W:0]          frac_sum;
   logic                      carry;
   logic signed [COORD_W-1:0] long_delta;
   logic signed [COORD_W-1:0] short_delta;
   logic                      in_frame;
   logic [INDEX_W:0]          index_full;
   logic [INDEX_W-1:0]        index_val;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_step   = (entry.command == CMD_STEP);
   assign entry_pop = entry_valid && (!is_step || !active_ff || out_free);
   assign emit      = entry_pop && is_step && active_ff;
   assign load      = entry_pop && !is_step;
   assign last_pix  = (remain_ff == COORD_W'(1));

   // Exact quotient tracking: remainder plus short length, one subtract
   assign frac_sum    = {1'b0, frac_ff} + {1'b0, short_len_ff};
   assign carry       = (frac_sum >= {1'b0, long_len_ff});
   assign long_delta  = long_neg_ff ? -COORD_W'(1) : COORD_W'(1);
   assign short_delta = short_neg_ff ? -COORD_W'(1) : COORD_W'(1);

   // Clip test and frame index; both factors widened so the product keeps all bits
   assign in_frame = !cur_x_ff[COORD_W-1] && !cur_y_ff[COORD_W-1] &&
                     ({1'b0, cur_x_ff} < (COORD_W+1)'(frame_width)) &&
                     ({1'b0, cur_y_ff} < (COORD_W+1)'(frame_height));
   assign index_full = (INDEX_W+1)'(cur_x_ff[IN_FRAME_W-1:0]) +
                       (INDEX_W+1)'(cur_y_ff[IN_FRAME_W-1:0]) *
                       (INDEX_W+1)'(frame_width);
   assign index_val  = in_frame ? index_full[INDEX_W-1:0] : '0;

   // Walker next state
   always_comb begin
      active_in = active_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      remain_in = remain_ff;
      frac_in   = frac_ff;
      if (load) begin
         active_in = (entry.long_len != '0);
         cur_x_in  = entry.origin_x;
         cur_y_in  = entry.origin_y;
         remain_in = entry.long_len;
         frac_in   = '0;
      end else if (emit) begin
         remain_in = remain_ff - COORD_W'(1);
         frac_in   = carry ? COORD_W'(frac_sum - {1'b0, long_len_ff}) : frac_sum[COORD_W-1:0];
         if (last_pix) begin
            active_in = 1'b0;
         end
         if (row_major_ff) begin
            cur_y_in = cur_y_ff + long_delta;
            cur_x_in = carry ? cur_x_ff + short_delta : cur_x_ff;
         end else begin
            cur_x_in = cur_x_ff + long_delta;
            cur_y_in = carry ? cur_y_ff + short_delta : cur_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      remain_ff <= remain_in;
      frac_ff   <= frac_in;
      if (load) begin
         long_len_ff  <= entry.long_len;
         short_len_ff <= entry.short_len;
         long_neg_ff  <= entry.long_neg;
         short_neg_ff <= entry.short_neg;
         row_major_ff <= entry.row_major;
         color_ff     <= entry.color;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_inside_ff <= in_frame;
         rsp_index_ff  <= index_val;
         rsp_color_ff  <= color_ff;
         rsp_last_ff   <= last_pix;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inside_res  = rsp_inside_ff;
   assign rsp_pixel_index = rsp_index_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ src/clipped_line_rasterizer_top.sv @@
// Line rasterizer with frame clipping.
// With the queue empty and the result free, a step request is held in the queue
// register and then in the result register before its pixel shows.
// Throughput: one request per cycle unless the queue is full or the result stalls;
// one pixel per step, set by the line walker's quotient update and the index multiply.
// Reset (synchronous, active high) empties the queue, ends any line and sets
// frame size to 320 x 200.
module clipped_line_rasterizer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [crl_pkg::COLOR_W-1:0]          req_line_color,
   input  logic signed [crl_pkg::COORD_W-1:0]   req_start_x,
   input  logic signed [crl_pkg::COORD_W-1:0]   req_start_y,
   input  logic signed [crl_pkg::COORD_W-1:0]   req_end_x,
   input  logic signed [crl_pkg::COORD_W-1:0]   req_end_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_inside_res,
   output logic [crl_pkg::INDEX_W-1:0]          rsp_pixel_index,
   output logic [crl_pkg::COLOR_W-1:0]          rsp_pixel_color,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [crl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [crl_pkg::DIM_W-1:0]            csr_wdata
);
   import crl_pkg::*;

   logic [DIM_W-1:0] frame_width_ff;
   logic [DIM_W-1:0] frame_height_ff;
   logic [DIM_W-1:0] wdata_sat;
   logic             csr_write;
   logic             queue_full;
   logic             push_valid;
   line_entry_type   push_entry;
   logic             pop;
   logic             pop_valid;
   line_entry_type   pop_entry;

   // Frame size registers, saturated on write
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign wdata_sat = (csr_wdata > DIM_LIMIT) ? DIM_LIMIT : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= wdata_sat;
            CSR_FRAME_HEIGHT: frame_height_ff <= wdata_sat;
            default: ;
         endcase
      end
   end

   crl_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_line_color (req_line_color),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_entry     (push_entry)
   );

   crl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   crl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .frame_width     (frame_width_ff),
      .frame_height    (frame_height_ff),
      .entry_valid     (pop_valid),
      .entry           (pop_entry),
      .entry_pop       (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

endmodule

@@ sim/clipped_line_rasterizer_top_tb.sv @@
module clipped_line_rasterizer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crl_pkg::*;

   localparam int      PHASES          = 6;
   localparam int      ITEMS_PER_PHASE = 200;
   localparam int      LONG_HOLD       = 300;
   localparam int      DRAIN_CYCLES    = 4;
   localparam int      CYCLE_LIMIT     = 500000;

   // indexes past the register map, writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = CSR_INDEX_W'(3);

   typedef struct packed {
      logic               in_frame;
      logic [INDEX_W-1:0] index;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_type;

   localparam pixel_type NO_PIX = '0;

   typedef struct {
      logic                      cmd;
      logic [COLOR_W-1:0]        color;
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] ey;
      bit                        typed;
      pixel_type                 pix;
   } stim_row_type;

   // DUT signals
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_command = CMD_START;
   logic [COLOR_W-1:0]        req_line_color = '0;
   logic signed [COORD_W-1:0] req_start_x = '0;
   logic signed [COORD_W-1:0] req_start_y = '0;
   logic signed [COORD_W-1:0] req_end_x = '0;
   logic signed [COORD_W-1:0] req_end_y = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_inside_res;
   logic [INDEX_W-1:0]        rsp_pixel_index;
   logic [COLOR_W-1:0]        rsp_pixel_color;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = CSR_FRAME_WIDTH;
   logic [DIM_W-1:0]          csr_wdata = '0;

   // typed expectation riding along with the request on the bus
   bit        cur_typed = 1'b0;
   pixel_type cur_pixel = NO_PIX;

   // line walker mirror
   longint      frame_cols = 320;
   longint      frame_rows = 200;
   longint      anchor_x, anchor_y;
   longint      minor_delta, major_delta;
   longint      walk_pos, minor_quot, minor_rem;
   bit          y_major;
   bit          walking = 1'b0;
   logic [31:0] line_color_q;

   pixel_type pending_pixels[$];
   pixel_type predicted, got_pix;
   int        mismatches = 0;

   // shared pacing controls
   bit          calm = 1'b0;
   int          hold_requests = 0;
   int          holds_taken = 0;
   int unsigned hold_left = 0;

   clipped_line_rasterizer_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_line_color  (req_line_color),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint span_len(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint dim_clamp(input logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : longint'(v);
   endfunction

   // Advance the walker by one request; returns 1 when a pixel comes out.
   function automatic bit trace_pixel(input logic cmd, input logic [COLOR_W-1:0] color,
                                      input logic signed [COORD_W-1:0] sx,
                                      input logic signed [COORD_W-1:0] sy,
                                      input logic signed [COORD_W-1:0] ex,
                                      input logic signed [COORD_W-1:0] ey,
                                      output pixel_type pix);
      longint dx, dy, len_l, len_s, along, across, px, py;
      pix = NO_PIX;
      if (cmd == CMD_START) begin
         dx = longint'(ex) - longint'(sx);
         dy = longint'(ey) - longint'(sy);
         anchor_x     = longint'(sx);
         anchor_y     = longint'(sy);
         line_color_q = color;
         // x wins a tie
         if (span_len(dy) > span_len(dx)) begin
            minor_delta = dx;
            major_delta = dy;
            y_major     = 1'b1;
         end else begin
            minor_delta = dy;
            major_delta = dx;
            y_major     = 1'b0;
         end
         walk_pos   = 0;
         minor_quot = 0;
         minor_rem  = 0;
         walking    = (major_delta != 0);
         return 1'b0;
      end
      if (!walking)
         return 1'b0;

      len_l  = span_len(major_delta);
      len_s  = span_len(minor_delta);
      along  = (major_delta < 0) ? -walk_pos : walk_pos;
      across = (minor_delta < 0) ? -minor_quot : minor_quot;
      if (y_major) begin
         px = anchor_x + across;
         py = anchor_y + along;
      end else begin
         px = anchor_x + along;
         py = anchor_y + across;
      end
      pix.in_frame = (px >= 0) && (py >= 0) && (px < frame_cols) && (py < frame_rows);
      if (pix.in_frame)
         pix.index = INDEX_W'(px + py * frame_cols);
      pix.color = line_color_q;
      pix.last  = (walk_pos + 1 == len_l);

      // exact trunc(i*short/long) kept as quotient and remainder
      walk_pos++;
      minor_rem += len_s;
      if (minor_rem >= len_l) begin
         minor_rem -= len_l;
         minor_quot++;
      end
      if (pix.last)
         walking = 1'b0;
      return 1'b1;
   endfunction

   // Mirror register writes, predict on accepted requests, check accepted pixels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  frame_cols = dim_clamp(csr_wdata);
               CSR_FRAME_HEIGHT: frame_rows = dim_clamp(csr_wdata);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (trace_pixel(req_command, req_line_color, req_start_x, req_start_y,
                            req_end_x, req_end_y, predicted))
               pending_pixels.push_back(cur_typed ? cur_pixel : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               $error("unexpected pixel: index %0d color %h", rsp_pixel_index,
                      rsp_pixel_color);
               mismatches++;
            end else begin
               got_pix = pending_pixels.pop_front();
               if (rsp_inside_res !== got_pix.in_frame) begin
                  $error("inside_res: expected %0d, got %0d", got_pix.in_frame,
                         rsp_inside_res);
                  mismatches++;
               end
               if (rsp_pixel_index !== got_pix.index) begin
                  $error("pixel_index: expected %0d, got %0d", got_pix.index,
                         rsp_pixel_index);
                  mismatches++;
               end
               if (rsp_pixel_color !== got_pix.color) begin
                  $error("pixel_color: expected %h, got %h", got_pix.color,
                         rsp_pixel_color);
                  mismatches++;
               end
               if (rsp_last !== got_pix.last) begin
                  $error("last: expected %0d, got %0d", got_pix.last, rsp_last);
                  mismatches++;
               end
            end
         end
      end
   end

   // Pixel sink: random stall after each pixel, plus an occasional long hold
   always @(posedge clock) begin
      if (hold_requests != holds_taken) begin
         holds_taken = hold_requests;
         hold_left   = LONG_HOLD;
      end else if (rsp_valid && !rsp_stall) begin
         hold_left = calm ? 0 : $urandom_range(0, 11);
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one request after a random gap, return once it is taken
   task automatic send_request(input logic cmd, input logic [COLOR_W-1:0] color,
                               input logic signed [COORD_W-1:0] sx,
                               input logic signed [COORD_W-1:0] sy,
                               input logic signed [COORD_W-1:0] ex,
                               input logic signed [COORD_W-1:0] ey,
                               input bit typed, input pixel_type typed_pix);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_line_color <= color;
      req_start_x    <= sx;
      req_start_y    <= sy;
      req_end_x      <= ex;
      req_end_y      <= ey;
      cur_typed      <= typed;
      cur_pixel      <= typed_pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_step();
      send_request(CMD_STEP, $urandom, COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom), COORD_W'($urandom), 1'b0, NO_PIX);
   endtask

   // Stop offering and wait until every predicted pixel has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high so back-to-back writes need no toggle
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [DIM_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // One random line: mostly short lines around the frame, usually walked just to the end
   task automatic draw_line(output int counted);
      int                        mode, pick, span, off_x, off_y;
      longint                    len, steps;
      logic signed [COORD_W-1:0] sx, sy, ex, ey;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         sx = COORD_W'($urandom);
         sy = COORD_W'($urandom);
         ex = COORD_W'($urandom);
         ey = COORD_W'($urandom);
      end else begin
         sx = COORD_W'(int'($urandom_range(0, 32'(frame_cols) + 16)) - 8);
         sy = COORD_W'(int'($urandom_range(0, 32'(frame_rows) + 16)) - 8);
         // far-off start, small delta, end may wrap
         if (mode == 1) begin
            sx = COORD_W'($urandom);
            sy = COORD_W'($urandom);
         end
         span  = (mode == 2) ? 200 : 24;
         off_x = int'($urandom_range(0, 2 * span)) - span;
         off_y = int'($urandom_range(0, 2 * span)) - span;
         ex    = COORD_W'(sx + off_x);
         ey    = COORD_W'(sy + off_y);
      end
      len = span_len(longint'(ex) - longint'(sx));
      if (span_len(longint'(ey) - longint'(sy)) > len)
         len = span_len(longint'(ey) - longint'(sy));

      pick = $urandom_range(0, 9);
      if (mode == 0)
         steps = $urandom_range(0, 6);
      else if (pick < 8)
         steps = len;
      else if (pick == 8)
         steps = $urandom_range(0, 32'(len));
      else
         steps = len + $urandom_range(1, 3);

      send_request(CMD_START, $urandom, sx, sy, ex, ey, 1'b0, NO_PIX);
      for (longint s = 0; s < steps; s++)
         send_step();
      counted = 1 + int'((steps < len) ? steps : len);
   endtask

   // Directed requests; typed rows carry their pixel, the rest use the walker
   stim_row_type directed_rows[$] = '{
      '{CMD_STEP,  32'h0000_0000, 0, 0, 0, 0, 1'b0, NO_PIX},   // nothing to walk after reset
      '{CMD_START, 32'hFFFF_FFFF, 0, 0, 3, 0, 1'b0, NO_PIX},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b1, '{1'b1, 24'd0, 32'hFFFF_FFFF, 1'b0}},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b1, '{1'b1, 24'd1, 32'hFFFF_FFFF, 1'b0}},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b1, '{1'b1, 24'd2, 32'hFFFF_FFFF, 1'b1}},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b0, NO_PIX},            // line already done
      '{CMD_START, 32'h0000_0000, -32768, -32768, 32767, 32767, 1'b0, NO_PIX},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b1, '{1'b0, 24'd0, 32'h0, 1'b0}},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b1, '{1'b0, 24'd0, 32'h0, 1'b0}},
      // restart mid-line, negative long axis
      '{CMD_START, 32'hA5A5_A5A5, 32767, 32767, -32768, -32768, 1'b0, NO_PIX},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b1, '{1'b0, 24'd0, 32'hA5A5_A5A5, 1'b0}},
      '{CMD_START, 32'h5A5A_5A5A, 5, 5, 5, 5, 1'b0, NO_PIX},     // zero length
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b0, NO_PIX},
      '{CMD_START, 32'h1234_5678, 10, 20, 7, 10, 1'b0, NO_PIX},  // y major, both negative
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b0, NO_PIX},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b0, NO_PIX},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b0, NO_PIX},
      '{CMD_START, 32'h0F0F_0F0F, 319, 199, 321, 199, 1'b0, NO_PIX}, // frame corner
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b1, '{1'b1, 24'd63999, 32'h0F0F_0F0F, 1'b0}},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b1, '{1'b0, 24'd0, 32'h0F0F_0F0F, 1'b1}},
      '{CMD_START, 32'h8000_0001, 0, -1, -2, 1, 1'b0, NO_PIX},   // tie, x major
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b0, NO_PIX},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b0, NO_PIX},
      '{CMD_START, 32'hC3C3_C3C3, 200, 3, 203, 40, 1'b0, NO_PIX},
      '{CMD_STEP,  32'h0, 0, 0, 0, 0, 1'b0, NO_PIX}
   };

   // frame sizes per phase; phase 0 runs at reset size
   logic [DIM_W-1:0] phase_cols [PHASES] = '{13'd320, 13'd4096, 13'h1FFF, 13'd0, 13'd1, 13'd640};
   logic [DIM_W-1:0] phase_rows [PHASES] = '{13'd200, 13'd4096, 13'd1, 13'd200, 13'd0, 13'd480};

   // Run-length guard
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // Main sequence
   initial begin
      int done, n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].cmd, directed_rows[i].color, directed_rows[i].sx,
                      directed_rows[i].sy, directed_rows[i].ex, directed_rows[i].ey,
                      directed_rows[i].typed, directed_rows[i].pix);

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            wait_drained();
            write_csr(CSR_FRAME_WIDTH, phase_cols[p]);
            write_csr(CSR_FRAME_HEIGHT, phase_rows[p]);
            if (p == 2) begin
               write_csr(CSR_SPARE_A, DIM_W'($urandom));
               write_csr(CSR_SPARE_B, DIM_W'($urandom));
            end
            csr_valid <= 1'b0;
         end

         // back up the pixel path: long sink hold while steps keep coming
         if (p == PHASES - 1) begin
            calm = 1'b1;
            send_request(CMD_START, $urandom, 0, 0, 250, 60, 1'b0, NO_PIX);
            hold_requests++;
            for (int s = 0; s < 250; s++)
               send_step();
            calm = 1'b0;
            wait_drained();
         end

         done = 0;
         while (done < ITEMS_PER_PHASE) begin
            calm = ($urandom_range(0, 5) == 0);
            draw_line(n);
            done += n;
         end
         calm = 1'b0;
      end

      wait_drained();
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
